[hw/rtl/rpt_pkg.sv]
package rpt_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned MAX_RESULTS = 16;

  localparam int unsigned IDX_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RES_W  = $clog2(MAX_RESULTS + 1);
  localparam int unsigned ID_W   = 32;
  localparam int unsigned WAIT_W = 16;
  localparam int unsigned RTY_W  = 4;
  localparam int unsigned EV_W   = 3;
  localparam int unsigned ACT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [WAIT_W-1:0] WAIT_MAX   = '1;
  localparam logic [WAIT_W-1:0] TMO_RESET  = 16'd10;
  localparam logic [RTY_W-1:0]  RLIM_RESET = 4'd3;

  // Input action codes
  localparam logic [ACT_W-1:0] ACT_ADD  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_ACK  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TICK = 2'd2;

  // Result event codes
  localparam logic [EV_W-1:0] EV_ADDED     = 3'd0;
  localparam logic [EV_W-1:0] EV_FULL      = 3'd1;
  localparam logic [EV_W-1:0] EV_ACK_MATCH = 3'd2;
  localparam logic [EV_W-1:0] EV_ACK_NONE  = 3'd3;
  localparam logic [EV_W-1:0] EV_RESEND    = 3'd4;
  localparam logic [EV_W-1:0] EV_FAILED    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT = 1'd1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_ADD   = 5'b00010,
    ST_ACK   = 5'b00100,
    ST_TICK  = 5'b01000,
    ST_FLUSH = 5'b10000
  } state_e;

  typedef struct packed {
    logic accept;
    logic add;
    logic ack_step;
    logic tick_step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic tmo_hit;
    logic id_hit;
    logic pend_valid;
    logic out_free;
  } stat_t;

endpackage

[hw/rtl/rpt_ctrl.sv]
module rpt_ctrl
  import rpt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic [ACT_W-1:0] action_i,
  input  logic             link_up_i,
  input  stat_t            stat_i,
  output cmd_t             cmd_o,
  output logic             busy_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          case (action_i)
            ACT_ADD:  state_d = ST_ADD;
            ACT_ACK:  state_d = ST_ACK;
            ACT_TICK: state_d = link_up_i ? ST_TICK : ST_IDLE;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = ST_FLUSH;
      end
      ST_ACK: begin
        cmd_o.ack_step = 1'b1;
        if (stat_i.scan_done || stat_i.id_hit) begin
          state_d = ST_FLUSH;
        end
      end
      ST_TICK: begin
        // hold the walk while a held result cannot move on
        if (stat_i.scan_done) begin
          state_d = ST_FLUSH;
        end else if (!(stat_i.tmo_hit && stat_i.pend_valid && !stat_i.out_free)) begin
          cmd_o.tick_step = 1'b1;
        end
      end
      ST_FLUSH: begin
        if (!stat_i.pend_valid) begin
          state_d = ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != ST_IDLE);

endmodule

[hw/rtl/rpt_dpath.sv]
module rpt_dpath
  import rpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [ID_W-1:0]       msg_id_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  cmd_t                  cmd_i,
  output stat_t                 stat_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [EV_W-1:0]       event_res_o,
  output logic [ID_W-1:0]       out_id_o,
  output logic [RTY_W-1:0]      retry_count_o,
  output logic                  last_o
);

  logic [WAIT_W-1:0] tmo_q;
  logic [RTY_W-1:0]  rlim_q;

  logic [ID_W-1:0]   slot_id_q   [TABLE_DEPTH];
  logic [RTY_W-1:0]  slot_rty_q  [TABLE_DEPTH];
  logic [WAIT_W-1:0] slot_wait_q [TABLE_DEPTH];
  logic [CNT_W-1:0]  occ_q;
  logic [CNT_W-1:0]  idx_q;
  logic [RES_W-1:0]  res_cnt_q;
  logic [ID_W-1:0]   id_q;

  logic              pend_valid_q;
  logic [EV_W-1:0]   pend_ev_q;
  logic [ID_W-1:0]   pend_id_q;
  logic [RTY_W-1:0]  pend_rty_q;

  logic              out_valid_q;
  logic [EV_W-1:0]   out_ev_q;
  logic [ID_W-1:0]   out_id_q;
  logic [RTY_W-1:0]  out_rty_q;
  logic              out_last_q;

  logic [ID_W-1:0]   rd_id;
  logic [RTY_W-1:0]  rd_rty;
  logic [WAIT_W-1:0] rd_wait;
  logic [WAIT_W-1:0] wait_inc;
  logic [WAIT_W-1:0] limit;
  logic [RTY_W-1:0]  rty_inc;
  logic              scan_done;
  logic              tmo_hit;
  logic              rty_spent;
  logic              id_hit;
  logic              out_free;
  logic              remove;
  logic              push_out;

  assign rd_id     = slot_id_q[idx_q[IDX_W-1:0]];
  assign rd_rty    = slot_rty_q[idx_q[IDX_W-1:0]];
  assign rd_wait   = slot_wait_q[idx_q[IDX_W-1:0]];
  assign scan_done = (idx_q >= occ_q);
  assign limit     = (tmo_q == '0) ? WAIT_W'(1) : tmo_q;
  assign wait_inc  = (rd_wait == WAIT_MAX) ? rd_wait : rd_wait + WAIT_W'(1);
  assign rty_inc   = rd_rty + RTY_W'(1);
  assign tmo_hit   = (wait_inc >= limit) && (res_cnt_q < RES_W'(MAX_RESULTS));
  assign rty_spent = (rd_rty >= rlim_q);
  assign id_hit    = (rd_id == id_q);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign remove   = (cmd_i.ack_step && !scan_done && id_hit) ||
                    (cmd_i.tick_step && tmo_hit && rty_spent);
  assign push_out = (cmd_i.tick_step && tmo_hit && pend_valid_q) ||
                    (cmd_i.flush && pend_valid_q);

  assign stat_o = '{scan_done:  scan_done,
                    tmo_hit:    tmo_hit,
                    id_hit:     id_hit,
                    pend_valid: pend_valid_q,
                    out_free:   out_free};

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tmo_q  <= TMO_RESET;
      rlim_q <= RLIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_ACK_TIMEOUT: tmo_q  <= cfg_data_i;
        REG_RETRY_LIMIT: rlim_q <= cfg_data_i[RTY_W-1:0];
        default: ;
      endcase
    end
  end

  // table payload
  always_ff @(posedge clk_i) begin
    if (remove) begin
      // close the gap: pull every later entry down one slot
      for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
        if (CNT_W'(j) >= idx_q) begin
          slot_id_q[j]   <= slot_id_q[j+1];
          slot_rty_q[j]  <= slot_rty_q[j+1];
          slot_wait_q[j] <= slot_wait_q[j+1];
        end
      end
    end else if (cmd_i.add && (occ_q < CNT_W'(TABLE_DEPTH))) begin
      slot_id_q[occ_q[IDX_W-1:0]]   <= id_q;
      slot_rty_q[occ_q[IDX_W-1:0]]  <= '0;
      slot_wait_q[occ_q[IDX_W-1:0]] <= '0;
    end else if (cmd_i.tick_step) begin
      if (tmo_hit) begin
        slot_rty_q[idx_q[IDX_W-1:0]]  <= rty_inc;
        slot_wait_q[idx_q[IDX_W-1:0]] <= '0;
      end else begin
        slot_wait_q[idx_q[IDX_W-1:0]] <= wait_inc;
      end
    end
  end

  // occupancy, walk index and result count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q     <= '0;
      idx_q     <= '0;
      res_cnt_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        idx_q     <= '0;
        res_cnt_q <= '0;
      end else if (cmd_i.ack_step && !scan_done && !id_hit) begin
        idx_q <= idx_q + CNT_W'(1);
      end else if (cmd_i.tick_step) begin
        if (tmo_hit) begin
          res_cnt_q <= res_cnt_q + RES_W'(1);
        end
        if (!remove) begin
          idx_q <= idx_q + CNT_W'(1);
        end
      end
      if (remove) begin
        occ_q <= occ_q - CNT_W'(1);
      end else if (cmd_i.add && (occ_q < CNT_W'(TABLE_DEPTH))) begin
        occ_q <= occ_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      id_q <= msg_id_i;
    end
  end

  // held result: stays until the next one shows whether it is the last
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (cmd_i.add || cmd_i.ack_step) begin
      pend_valid_q <= (cmd_i.add || scan_done || id_hit);
    end else if (cmd_i.tick_step && tmo_hit) begin
      pend_valid_q <= 1'b1;
    end else if (cmd_i.flush) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.add) begin
      pend_ev_q  <= (occ_q < CNT_W'(TABLE_DEPTH)) ? EV_ADDED : EV_FULL;
      pend_id_q  <= id_q;
      pend_rty_q <= '0;
    end else if (cmd_i.ack_step) begin
      pend_ev_q  <= (!scan_done && id_hit) ? EV_ACK_MATCH : EV_ACK_NONE;
      pend_id_q  <= id_q;
      pend_rty_q <= (!scan_done && id_hit) ? rd_rty : '0;
    end else if (cmd_i.tick_step && tmo_hit) begin
      pend_ev_q  <= rty_spent ? EV_FAILED : EV_RESEND;
      pend_id_q  <= rd_id;
      pend_rty_q <= rty_spent ? rd_rty : rty_inc;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_out) begin
      out_ev_q   <= pend_ev_q;
      out_id_q   <= pend_id_q;
      out_rty_q  <= pend_rty_q;
      out_last_q <= cmd_i.flush;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign event_res_o   = out_ev_q;
  assign out_id_o      = out_id_q;
  assign retry_count_o = out_rty_q;
  assign last_o        = out_last_q;

endmodule

[hw/rtl/retransmit_pending_tracker.sv]
// Retransmit pending tracker: a table of up to 16 message ids waiting for ack.
// Input channel (in_valid_i / in_stall_o) carries action_i, msg_id_i and
// link_up_i; a word is taken when valid is high and stall is low. Add appends
// an id if the table has room, ack removes the oldest matching entry, tick
// (with link up) ages all entries and retries or fails those that time out.
// Output channel (out_valid_o / out_stall_i) gives one result word per event;
// last_o marks the final word caused by an input word.
// Config channel (cfg_valid_i / cfg_ready_o) writes ack_timeout_ticks (index 0)
// and retry_limit (index 1); write only while no input word is in flight.
// Timing: one input word at a time. Ack walks the entry registers up to the
// match, or over all entries on a miss, and tick over all entries, one
// entry per cycle; the tick walk pauses while a stalled receiver holds
// back a due result.
// A held result sits in a one-word buffer ahead of the output register, so
// a stalled receiver pauses the tick walk only when a new result is due.
// Reset empties the table, restores timeout 10 and retry limit 3, and
// drops any result word in flight.
module retransmit_pending_tracker
  import rpt_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [ACT_W-1:0]      action_i,
  input  logic [ID_W-1:0]       msg_id_i,
  input  logic                  link_up_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [EV_W-1:0]       event_res_o,
  output logic [ID_W-1:0]       out_id_o,
  output logic [RTY_W-1:0]      retry_count_o,
  output logic                  last_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t  cmd;
  stat_t stat;
  logic  busy;

  // config writes land at once; the host is to write only while idle, which the block does not enforce
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;

  rpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .action_i   (action_i),
    .link_up_i  (link_up_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  rpt_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .msg_id_i      (msg_id_i),
    .cfg_we_i      (cfg_valid_i && cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .event_res_o   (event_res_o),
    .out_id_o      (out_id_o),
    .retry_count_o (retry_count_o),
    .last_o        (last_o)
  );

  // no held result may survive into the next input word
  a_idle_no_pend : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> !stat.pend_valid)
    else $error("held result left over while idle");

  // add and ack give exactly one result word, so it must be the last
  a_single_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (event_res_o == EV_ADDED || event_res_o == EV_FULL ||
                    event_res_o == EV_ACK_MATCH || event_res_o == EV_ACK_NONE)
    |-> last_o)
    else $error("add or ack result without last");

  // the tick walk never steps past the filled part of the table
  a_walk_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.tick_step |-> !stat.scan_done)
    else $error("tick step beyond occupancy");

endmodule
